// ===== hw/rtl/sae_pkg.sv =====
// sae_pkg: shared types and constants for the stack arithmetic engine
// no dependencies; imported by every module of the block
package sae_pkg;

    localparam int WORD_W  = 32;
    localparam int DEPTH_W = 7;
    localparam int DIV_CW  = $clog2(WORD_W);

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_SWAP = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_DIV  = 3'd4,
        OP_MUL  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EXEC   = 2'd1,
        S_DIVW   = 2'd2,
        S_FINISH = 2'd3
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic exec;
        logic div_commit;
        logic out_load;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic div_go;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/stack_arith_engine_core.sv =====
// stack arithmetic engine: push, swap, add, subtract, multiply, divide on a word stack
// sequence: take with registered stack read, execute, optional divide wait, then load into the result register
// overlap: one transaction at a time; the next is taken as the previous result moves into the output register
// divide: 32 divider steps plus the registered divider done
// reset: synchronous active low; clears entry count, state machine and result valid
// depends on sae_pkg, sae_ctrl, sae_dpath, sae_div
module stack_arith_engine_core #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_req_type,
    input  logic signed [31:0] i_push_value,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_top_value,
    output logic [6:0]         o_stack_depth
);
    import sae_pkg::*;

    t_ctl ctl;
    t_sts sts;
    logic ready;

    // a new transaction is taken when idle, or while the finished result
    // moves into the output register
    assign o_stall = !ready;

    // controller: idle -> execute -> (divide wait) -> finish
    sae_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (ready),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    // datapath: top of stack cached in a register, the rest in memory,
    // so each operation needs a single registered read of the second entry
    sae_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_req_type    (i_req_type),
        .i_push_value  (i_push_value),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_top_value   (o_top_value),
        .o_stack_depth (o_stack_depth)
    );

endmodule

// ===== hw/rtl/sae_div.sv =====
// sae_div: iterative signed divider, one quotient bit per cycle, truncating
// depends on sae_pkg
module sae_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  sae_pkg::t_word i_dividend,
    input  sae_pkg::t_word i_divisor,
    output logic          o_done,
    output sae_pkg::t_word o_quotient
);
    import sae_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_quo;
    logic [WORD_W-1:0] r_den;
    logic              r_neg;

    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   shifted;
    logic [WORD_W-1:0] mag_a;
    logic [WORD_W-1:0] mag_b;

    assign mag_a   = i_dividend[WORD_W-1] ? WORD_W'(-i_dividend) : WORD_W'(i_dividend);
    assign mag_b   = i_divisor[WORD_W-1]  ? WORD_W'(-i_divisor)  : WORD_W'(i_divisor);
    assign shifted = {r_rem, r_quo[WORD_W-1]};
    assign trial   = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == DIV_CW'(WORD_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CW'(1);
                if (r_cnt == DIV_CW'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= mag_a;
            r_den <= mag_b;
            r_neg <= i_dividend[WORD_W-1] ^ i_divisor[WORD_W-1];
        end else if (r_busy) begin
            // restoring step
            r_rem <= trial[WORD_W] ? shifted[WORD_W-1:0] : trial[WORD_W-1:0];
            r_quo <= {r_quo[WORD_W-2:0], ~trial[WORD_W]};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? t_word'(-r_quo) : t_word'(r_quo);

endmodule

// ===== hw/rtl/sae_dpath.sv =====
// sae_dpath: stack memory, cached top register, alu, divider and result register
// depends on sae_pkg and sae_div
module sae_dpath #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sae_pkg::t_ctl                i_ctl,
    output sae_pkg::t_sts                o_sts,
    input  logic [2:0]                   i_req_type,
    input  logic signed [31:0]           i_push_value,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic signed [31:0]           o_top_value,
    output logic [6:0]                   o_stack_depth
);
    import sae_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // entries below the top; the top itself lives in r_top
    t_word          mem [STACK_DEPTH];

    logic [CW-1:0]  r_count;
    t_word          r_top;
    t_word          r_rd;
    logic [2:0]     r_op;
    t_word          r_pv;
    t_status        r_status;
    logic           r_ovalid;
    logic [1:0]     r_ostatus;
    t_word          r_otop;
    logic [6:0]     r_odepth;

    logic           is_short;
    logic           is_full;
    logic           top_zero;
    logic           we;
    logic [AW-1:0]  wa;
    logic [AW-1:0]  ra;
    t_word          alu;
    t_word          quot;
    logic           div_done;
    logic           div_go;
    logic           out_free;

    assign is_short = r_count < CW'(2);
    assign is_full  = r_count == CW'(STACK_DEPTH);
    assign top_zero = r_top == '0;
    assign ra       = AW'(r_count - CW'(2));
    assign div_go   = i_ctl.exec && (r_op == OP_DIV) && !is_short && !top_zero;
    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        case (r_op)
            OP_ADD:  alu = r_rd + r_top;
            OP_SUB:  alu = r_rd - r_top;
            default: alu = t_word'(r_rd * r_top);
        endcase
    end

    // memory write: spill the old top on push, second slot on swap
    always_comb begin
        we = 1'b0;
        wa = AW'(r_count - CW'(2));
        if (i_ctl.exec) begin
            if (r_op == OP_PUSH && !is_full && r_count != '0) begin
                we = 1'b1;
                wa = AW'(r_count - CW'(1));
            end else if (r_op == OP_SWAP && !is_short) begin
                we = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= r_top;
        end
        if (i_ctl.take) begin
            r_rd <= mem[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_op <= i_req_type;
            r_pv <= i_push_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_status <= ST_OK;
        end else if (i_ctl.div_commit) begin
            r_top    <= quot;
            r_count  <= r_count - CW'(1);
            r_status <= ST_OK;
        end else if (i_ctl.exec) begin
            case (r_op) inside
                OP_PUSH: begin
                    if (is_full) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_top    <= r_pv;
                        r_count  <= r_count + CW'(1);
                        r_status <= ST_OK;
                    end
                end
                OP_SWAP: begin
                    if (is_short) begin
                        r_status <= ST_SHORT;
                    end else begin
                        r_top    <= r_rd;
                        r_status <= ST_OK;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL: begin
                    if (is_short) begin
                        r_status <= ST_SHORT;
                    end else begin
                        r_top    <= alu;
                        r_count  <= r_count - CW'(1);
                        r_status <= ST_OK;
                    end
                end
                OP_DIV: begin
                    if (is_short) begin
                        r_status <= ST_SHORT;
                    end else if (top_zero) begin
                        r_status <= ST_DIVZERO;
                    end else begin
                        r_status <= ST_OK;
                    end
                end
                default: begin
                    r_status <= ST_OK;
                end
            endcase
        end
    end

    sae_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend (r_rd),
        .i_divisor  (r_top),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_ostatus <= r_status;
            r_otop    <= (r_count != '0) ? r_top : '0;
            r_odepth  <= DEPTH_W'(r_count);
        end
    end

    assign o_sts.div_go   = div_go;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = out_free;

    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_top_value   = r_otop;
    assign o_stack_depth = r_odepth;

endmodule

// ===== hw/rtl/sae_ctrl.sv =====
// sae_ctrl: sequencing state machine for the stack arithmetic engine
// depends on sae_pkg
module sae_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sae_pkg::t_sts i_sts,
    output sae_pkg::t_ctl o_ctl
);
    import sae_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_sts.div_go ? S_DIVW : S_FINISH;
            end
            S_DIVW: begin
                if (i_sts.div_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) n_state = i_valid ? S_EXEC : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready          = 1'b0;
        o_ctl.exec       = 1'b0;
        o_ctl.div_commit = 1'b0;
        o_ctl.out_load   = 1'b0;
        unique case (r_state)
            S_IDLE:   o_ready = 1'b1;
            S_EXEC:   o_ctl.exec = 1'b1;
            S_DIVW:   o_ctl.div_commit = i_sts.div_done;
            S_FINISH: begin
                o_ready        = i_sts.out_free;
                o_ctl.out_load = i_sts.out_free;
            end
            default: o_ready = 1'b0;
        endcase
        o_ctl.take = o_ready && i_valid;
    end

endmodule

// ===== hw/rtl/sae_checker.sv =====
// sae_checker: port-level assertions for the stack arithmetic engine, with its bind
// depends on sae_pkg and stack_arith_engine_core
module sae_checker #(
    parameter int STACK_DEPTH = 64
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [1:0]         o_status,
    input logic signed [31:0] o_top_value,
    input logic [6:0]         o_stack_depth
);
    import sae_pkg::*;

    localparam logic [6:0] DepthLow = 7'(STACK_DEPTH);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_top_value)
            && $stable(o_stack_depth))
        else $error("stalled result changed");

    // one transaction in work at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request taken while previous one executing");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stack_depth == 7'd0 && STACK_DEPTH < 128 |-> o_top_value == '0)
        else $error("empty stack with nonzero top");

    a_short_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_SHORT |-> o_stack_depth < 7'd2)
        else $error("too-short status with two or more entries");

    a_full_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_stack_depth == DepthLow)
        else $error("full status with stack not full");

endmodule

bind stack_arith_engine_core sae_checker #(.STACK_DEPTH(STACK_DEPTH)) u_sae_checker (.*);
